@@ rtl/kf2_pkg.sv @@
// shared constants, register addresses, reset values and op codes for the two-state kalman filter
package kf2_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IN_W  = 32;
  localparam int CFG_W = 31;
  localparam int ADDR_W = 5;

  localparam logic [ADDR_W-1:0] REG_PROCESS_NOISE   = 5'd0;
  localparam logic [ADDR_W-1:0] REG_VIB_MEAS_NOISE  = 5'd4;
  localparam logic [ADDR_W-1:0] REG_DIST_NOISE_NEAR = 5'd8;
  localparam logic [ADDR_W-1:0] REG_DIST_NOISE_FAR  = 5'd12;
  localparam logic [ADDR_W-1:0] REG_NEAR_THRESHOLD  = 5'd16;

  localparam logic [30:0] PROCESS_NOISE_RST   = 31'd655;
  localparam logic [30:0] VIB_MEAS_NOISE_RST  = 31'd6554;
  localparam logic [30:0] DIST_NOISE_NEAR_RST = 31'd3277;
  localparam logic [30:0] DIST_NOISE_FAR_RST  = 31'd13107;
  localparam logic [31:0] NEAR_THRESHOLD_RST  = 32'd65536000;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } alu_op_t;

endpackage

@@ rtl/kf2_alu.sv @@
// shared arithmetic unit: rounded fixed-point multiply, saturating add and subtract
module kf2_alu import kf2_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  alu_op_t                      op,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] y
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic neg;
  logic [DATA_WIDTH-1:0] ma, mb;
  logic [PW-1:0] prod, prnd;
  logic [PW-1:0] mq;
  logic signed [DATA_WIDTH:0] sum;
  logic signed [DATA_WIDTH-1:0] mres, sres;

  always_comb begin
    neg  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    ma   = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
    mb   = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
    prod = PW'(ma) * PW'(mb);
    prnd = prod + (PW'(1) << (FRAC_BITS - 1));
    mq   = prnd >> FRAC_BITS;
    if (neg) begin
      if (mq > PW'(VMAX) + PW'(1)) mres = VMIN;
      else mres = DATA_WIDTH'(-mq);
    end else begin
      if (mq > PW'(VMAX)) mres = VMAX;
      else mres = DATA_WIDTH'(mq);
    end
    if (op == OP_SUB) sum = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    else sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) sres = sum[DATA_WIDTH] ? VMIN : VMAX;
    else sres = sum[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    y <= (op == OP_MUL) ? mres : sres;
  end

endmodule

@@ rtl/kf2_recip.sv @@
// iterative reciprocal: round(2^(2*frac)/d), one quotient bit per cycle
module kf2_recip import kf2_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] d,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] q
);

  localparam int NW = 2 * FRAC_BITS + 2;
  localparam int CW = $clog2(NW + 1);
  localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic busy, neg;
  logic [CW-1:0] cnt;
  logic [DATA_WIDTH-1:0] md;
  logic [NW-1:0] num, quo;
  logic [DATA_WIDTH:0] rem, trial;
  logic [NW-1:0] qm;

  always_comb begin
    trial = {rem[DATA_WIDTH-1:0], num[NW-1]} - {1'b0, md};
    qm = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        neg  <= d[DATA_WIDTH-1];
        md   <= d[DATA_WIDTH-1] ? DATA_WIDTH'(-d) : DATA_WIDTH'(d);
        num  <= (NW'(1) << (2 * FRAC_BITS)) + (NW'(d[DATA_WIDTH-1] ? DATA_WIDTH'(-d) :
                DATA_WIDTH'(d)) >> 1);
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        if (!trial[DATA_WIDTH]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[DATA_WIDTH-1:0], num[NW-1]};
          quo <= {quo[NW-2:0], 1'b0};
        end
        num <= {num[NW-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (qm > NW'(VMAX) + NW'(1)) q = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else q = DATA_WIDTH'(-qm);
    end else begin
      if (qm > NW'(VMAX)) q = VMAX;
      else q = DATA_WIDTH'(qm);
    end
  end

endmodule

@@ rtl/kalman_filter_2state.sv @@
// top level of the two-state kalman filter with apb configuration
// usage:
//   input words (dist_meas, vib_meas) arrive on a valid/ready channel; one result
//   word (est_dist_out, est_vib_out, update_skipped) leaves on a valid/ready channel
//   for every input word.
//   the block works on one word at a time: a shared multiply/add unit runs a
//   microprogram of 51 steps, each issued once the previous one has written
//   back, and a reciprocal unit finds the inverse of the determinant between
//   the first part of the microprogram and the rest; when the determinant is
//   zero the rest is skipped and the estimate is returned as it stands.
//   in_ready is high only when no word is in flight and the output register is free.
//   if the receiver stalls, the result holds in the output register and no new
//   word is taken until it is delivered.
//   reset restores the register defaults, clears the estimate, sets the
//   covariance to identity and marks the filter unprimed; the first word loads
//   the estimate from the measurement.
//   configuration must be written through the apb port only while idle; the block itself does not enforce it.
module kalman_filter_2state import kf2_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  dist_meas,
  input  logic signed [31:0]  vib_meas,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  est_dist_out,
  output logic signed [31:0]  est_vib_out,
  output logic                update_skipped
);

  localparam int DW = DATA_WIDTH;
  localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_RECIP = 5'b00100,
    ST_RUN2  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // register file indexes for operands
  typedef enum logic [4:0] {
    R_P0, R_P1, R_P2, R_P3, R_ED, R_EV, R_ZD, R_ZV, R_Q, R_R0, R_R1,
    R_YD, R_YV, R_S0, R_S3, R_T0, R_T1, R_DET, R_RC, R_I0, R_I1, R_I2, R_I3,
    R_K0, R_K1, R_K2, R_K3, R_ONE, R_ZERO, R_N0, R_N1, R_N2
  } reg_t;

  typedef struct packed {
    alu_op_t op;
    reg_t a;
    reg_t b;
    reg_t d;
  } uop_t;

  localparam int NA = 9;
  localparam int NB = 33;

  function automatic uop_t ua(input int i);
    uop_t u;
    u = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    case (i)
      0:  u = '{OP_ADD, R_P0, R_Q, R_P0};
      1:  u = '{OP_ADD, R_P3, R_Q, R_P3};
      2:  u = '{OP_SUB, R_ZD, R_ED, R_YD};
      3:  u = '{OP_SUB, R_ZV, R_EV, R_YV};
      4:  u = '{OP_ADD, R_P0, R_R0, R_S0};
      5:  u = '{OP_ADD, R_P3, R_R1, R_S3};
      6:  u = '{OP_MUL, R_S0, R_S3, R_T0};
      7:  u = '{OP_MUL, R_P1, R_P2, R_T1};
      8:  u = '{OP_SUB, R_T0, R_T1, R_DET};
      default: u = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    endcase
    return u;
  endfunction

  function automatic uop_t ub(input int i);
    uop_t u;
    case (i)
      0:  u = '{OP_MUL, R_S3, R_RC, R_I0};
      1:  u = '{OP_SUB, R_ZERO, R_P1, R_T0};
      2:  u = '{OP_SUB, R_ZERO, R_P2, R_T1};
      3:  u = '{OP_MUL, R_S0, R_RC, R_I3};
      4:  u = '{OP_MUL, R_T0, R_RC, R_I1};
      5:  u = '{OP_MUL, R_T1, R_RC, R_I2};
      6:  u = '{OP_MUL, R_P0, R_I0, R_T0};
      7:  u = '{OP_MUL, R_P1, R_I2, R_T1};
      8:  u = '{OP_ADD, R_T0, R_T1, R_K0};
      9:  u = '{OP_MUL, R_P0, R_I1, R_T0};
      10: u = '{OP_MUL, R_P1, R_I3, R_T1};
      11: u = '{OP_ADD, R_T0, R_T1, R_K1};
      12: u = '{OP_MUL, R_P2, R_I0, R_T0};
      13: u = '{OP_MUL, R_P3, R_I2, R_T1};
      14: u = '{OP_ADD, R_T0, R_T1, R_K2};
      15: u = '{OP_MUL, R_P2, R_I1, R_T0};
      16: u = '{OP_MUL, R_P3, R_I3, R_T1};
      17: u = '{OP_ADD, R_T0, R_T1, R_K3};
      18: u = '{OP_MUL, R_K0, R_YD, R_T0};
      19: u = '{OP_MUL, R_K1, R_YV, R_T1};
      20: u = '{OP_ADD, R_T0, R_T1, R_T0};
      21: u = '{OP_ADD, R_ED, R_T0, R_ED};
      22: u = '{OP_MUL, R_K2, R_YD, R_T0};
      23: u = '{OP_MUL, R_K3, R_YV, R_T1};
      24: u = '{OP_ADD, R_T0, R_T1, R_T0};
      25: u = '{OP_ADD, R_EV, R_T0, R_EV};
      26: u = '{OP_SUB, R_ONE, R_K0, R_I0};
      27: u = '{OP_SUB, R_ZERO, R_K1, R_I1};
      28: u = '{OP_SUB, R_ZERO, R_K2, R_I2};
      29: u = '{OP_SUB, R_ONE, R_K3, R_I3};
      // new p: rows of (i-k) times p, into n0..n2 then p
      30: u = '{OP_MUL, R_I0, R_P0, R_T0};
      31: u = '{OP_MUL, R_I1, R_P2, R_T1};
      32: u = '{OP_ADD, R_T0, R_T1, R_N0};
      default: u = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    endcase
    return u;
  endfunction

  // remaining new-p steps, kept as a second table
  localparam int NC = 9;
  function automatic uop_t uc(input int i);
    uop_t u;
    case (i)
      0: u = '{OP_MUL, R_I0, R_P1, R_T0};
      1: u = '{OP_MUL, R_I1, R_P3, R_T1};
      2: u = '{OP_ADD, R_T0, R_T1, R_N1};
      3: u = '{OP_MUL, R_I2, R_P0, R_T0};
      4: u = '{OP_MUL, R_I3, R_P2, R_T1};
      5: u = '{OP_ADD, R_T0, R_T1, R_N2};
      6: u = '{OP_MUL, R_I2, R_P1, R_T0};
      7: u = '{OP_MUL, R_I3, R_P3, R_T1};
      default: u = '{OP_ADD, R_T0, R_T1, R_P3};
    endcase
    return u;
  endfunction

  state_t state;
  logic [30:0] process_noise, vib_meas_noise, dist_noise_near, dist_noise_far;
  logic signed [31:0] near_threshold;
  logic primed;
  logic signed [DW-1:0] rf [32];
  logic [5:0] pc;
  logic phase_c;
  logic wb_pend;
  reg_t wb_dst;
  uop_t cur;
  logic signed [DW-1:0] alu_y;
  logic rc_start, rc_done;
  logic signed [DW-1:0] rc_q;
  logic signed [31:0] od, ov;
  logic oskip;

  function automatic logic signed [DW-1:0] sat_in(input logic signed [31:0] v);
    logic signed [DW-1:0] r;
    if (DW >= 32) r = DW'(v);
    else if (v > 32'(VMAX)) r = VMAX;
    else if (v < 32'(VMIN)) r = VMIN;
    else r = DW'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [DW-1:0] v);
    logic signed [31:0] r;
    if (DW <= 32) r = 32'(v);
    else if (v > DW'(32'sh7fffffff)) r = 32'sh7fffffff;
    else if (v < DW'(-64'sd2147483648)) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  always_comb begin
    if (state == ST_RUN) cur = ua(int'(pc));
    else if (phase_c) cur = uc(int'(pc));
    else cur = ub(int'(pc));
  end

  kf2_alu #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk(clk), .op(cur.op), .a(rf[cur.a]), .b(rf[cur.b]), .y(alu_y)
  );

  kf2_recip #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_recip (
    .clk(clk), .rst(rst), .start(rc_start), .d(rf[R_DET]), .done(rc_done), .q(rc_q)
  );

  assign pready = 1'b1;
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign est_dist_out = od;
  assign est_vib_out = ov;
  assign update_skipped = oskip;

  always_comb begin
    unique case (paddr)
      REG_PROCESS_NOISE:   prdata = {1'b0, process_noise};
      REG_VIB_MEAS_NOISE:  prdata = {1'b0, vib_meas_noise};
      REG_DIST_NOISE_NEAR: prdata = {1'b0, dist_noise_near};
      REG_DIST_NOISE_FAR:  prdata = {1'b0, dist_noise_far};
      REG_NEAR_THRESHOLD:  prdata = near_threshold;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise   <= PROCESS_NOISE_RST;
      vib_meas_noise  <= VIB_MEAS_NOISE_RST;
      dist_noise_near <= DIST_NOISE_NEAR_RST;
      dist_noise_far  <= DIST_NOISE_FAR_RST;
      near_threshold  <= NEAR_THRESHOLD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_PROCESS_NOISE:   process_noise   <= pwdata[30:0];
        REG_VIB_MEAS_NOISE:  vib_meas_noise  <= pwdata[30:0];
        REG_DIST_NOISE_NEAR: dist_noise_near <= pwdata[30:0];
        REG_DIST_NOISE_FAR:  dist_noise_far  <= pwdata[30:0];
        REG_NEAR_THRESHOLD:  near_threshold  <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rc_start <= 1'b0;
    if (rst) begin
      state     <= ST_IDLE;
      primed    <= 1'b0;
      out_valid <= 1'b0;
      wb_pend   <= 1'b0;
      phase_c   <= 1'b0;
      pc        <= '0;
      rf[R_ED] <= '0;
      rf[R_EV] <= '0;
      rf[R_P0] <= ONE;
      rf[R_P1] <= '0;
      rf[R_P2] <= '0;
      rf[R_P3] <= ONE;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (wb_pend) rf[wb_dst] <= alu_y;
      wb_pend <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            rf[R_ZD] <= sat_in(dist_meas);
            rf[R_ZV] <= sat_in(vib_meas);
            rf[R_Q]  <= sat_in({1'b0, process_noise});
            rf[R_R1] <= sat_in({1'b0, vib_meas_noise});
            rf[R_R0] <= sat_in({1'b0, (dist_meas < near_threshold) ? dist_noise_near
                                                                    : dist_noise_far});
            rf[R_ONE]  <= ONE;
            rf[R_ZERO] <= '0;
            if (!primed) begin
              rf[R_ED] <= sat_in(dist_meas);
              rf[R_EV] <= sat_in(vib_meas);
              rf[R_P0] <= ONE;
              rf[R_P1] <= '0;
              rf[R_P2] <= '0;
              rf[R_P3] <= ONE;
            end
            primed <= 1'b1;
            pc     <= '0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          // every step writes back in the cycle after it issues, the gap keeps operands ready
          if (!wb_pend) begin
            if (pc == 6'(NA)) begin
              state <= ST_RECIP;
            end else begin
              wb_pend <= 1'b1;
              wb_dst  <= cur.d;
              pc      <= pc + 6'd1;
            end
          end
        end
        ST_RECIP: begin
          if (rf[R_DET] == '0) begin
            od    <= sat_out(rf[R_ED]);
            ov    <= sat_out(rf[R_EV]);
            oskip <= 1'b1;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end else if (!rc_start && pc != 6'd0 && !rc_done) begin
            rc_start <= 1'b1;
            pc <= '0;
          end else if (rc_done) begin
            rf[R_RC] <= rc_q;
            pc <= '0;
            phase_c <= 1'b0;
            state <= ST_RUN2;
          end
        end
        ST_RUN2: begin
          if (!wb_pend) begin
            if (!phase_c && pc == 6'(NB)) begin
              phase_c <= 1'b1;
              pc <= '0;
            end else if (phase_c && pc == 6'(NC)) begin
              rf[R_P0] <= rf[R_N0];
              rf[R_P1] <= rf[R_N1];
              rf[R_P2] <= rf[R_N2];
              state <= ST_OUT;
            end else begin
              wb_pend <= 1'b1;
              wb_dst  <= cur.d;
              pc      <= pc + 6'd1;
            end
          end
        end
        ST_OUT: begin
          od    <= sat_out(rf[R_ED]);
          ov    <= sat_out(rf[R_EV]);
          oskip <= 1'b0;
          out_valid <= 1'b1;
          phase_c <= 1'b0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == ST_IDLE))
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(od) && $stable(ov)))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("accept while busy");

endmodule
